// File: rtl/mlkem_basemul_row_accumulate_defines.svh
// Assertion macros shared by the ML-KEM base multiplication RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef MLKEM_BASEMUL_ROW_ACCUMULATE_DEFINES_SVH
`define MLKEM_BASEMUL_ROW_ACCUMULATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBRA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold a fixed number of cycles after the antecedent.
`define MBRA_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##dly (cons)) else $error(msg);

`endif

// File: rtl/mbra_pkg.sv
`default_nettype none

package mbra_pkg;

  localparam int unsigned CoefW = 12;
  localparam int unsigned IdxW  = 7;

  typedef logic [CoefW-1:0] coef_t;
  typedef logic [IdxW-1:0]  idx_t;

  localparam coef_t Q = 12'd3329;

  // Zetas of index 64 to 127 in the bit-reversed order of the standard.
  localparam coef_t ZetaTab [64] = '{
    12'd17,   12'd2761, 12'd583,  12'd2649, 12'd1637, 12'd723,  12'd2288, 12'd1100,
    12'd1409, 12'd2662, 12'd3281, 12'd233,  12'd756,  12'd2156, 12'd3015, 12'd3050,
    12'd1703, 12'd1651, 12'd2789, 12'd1789, 12'd1847, 12'd952,  12'd1461, 12'd2687,
    12'd939,  12'd2308, 12'd2437, 12'd2388, 12'd733,  12'd2337, 12'd268,  12'd641,
    12'd1584, 12'd2298, 12'd2037, 12'd3220, 12'd375,  12'd2549, 12'd2090, 12'd1645,
    12'd1063, 12'd319,  12'd2773, 12'd757,  12'd2099, 12'd561,  12'd2466, 12'd2594,
    12'd2804, 12'd1092, 12'd403,  12'd1026, 12'd1143, 12'd2150, 12'd2775, 12'd886,
    12'd1722, 12'd1212, 12'd1874, 12'd1029, 12'd2110, 12'd2935, 12'd885,  12'd2154
  };

  // Twiddle of a pair: the zeta for even pairs, its negation for odd pairs.
  function automatic coef_t gamma_of(input idx_t idx);
    coef_t z;
    z = ZetaTab[idx[IdxW-1:1]];
    return idx[0] ? coef_t'(Q - z) : z;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mlkem_basemul_row_accumulate.sv
`default_nettype none

// ML-KEM base multiplication with row accumulation for one coefficient pair.
// Command channel: an item is taken at a rising edge with start_i high and
// busy_o low. The block is fully pipelined, so busy_o stays low and a new
// item may be issued in every cycle; throughput is one item per cycle.
// Result channel: done_o is high for exactly one cycle while out_pair_index_o,
// acc_even_o and acc_odd_o carry the result, and the transfer completes at the
// edge that ends that cycle. The receiver cannot stall, so results are never
// held back and must be captured when done_o is high.
// The stages are input capture, the eight coefficient products, the partial
// sums, a two-stage modular reduction of the odd-odd products, the twiddle
// product, the final sums and a two-stage reduction of both results.
// Results leave in the order in which items entered.
// Reset clears all valid bits; items in flight at reset are dropped and the
// block is ready in the first cycle after reset is released.
module mlkem_basemul_row_accumulate (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire mbra_pkg::idx_t  pair_index_i,
  input  wire mbra_pkg::coef_t mat0_even_i,
  input  wire mbra_pkg::coef_t mat0_odd_i,
  input  wire mbra_pkg::coef_t mat1_even_i,
  input  wire mbra_pkg::coef_t mat1_odd_i,
  input  wire mbra_pkg::coef_t sec0_even_i,
  input  wire mbra_pkg::coef_t sec0_odd_i,
  input  wire mbra_pkg::coef_t sec1_even_i,
  input  wire mbra_pkg::coef_t sec1_odd_i,
  input  wire mbra_pkg::coef_t err_even_i,
  input  wire mbra_pkg::coef_t err_odd_i,
  output logic                 done_o,
  output mbra_pkg::idx_t       out_pair_index_o,
  output mbra_pkg::coef_t      acc_even_o,
  output mbra_pkg::coef_t      acc_odd_o
);
  import mbra_pkg::*;
  `include "mlkem_basemul_row_accumulate_defines.svh"

  localparam int unsigned ProdW = 2 * CoefW;
  localparam int unsigned HiW   = ProdW + 1;
  localparam int unsigned EvW   = ProdW + 2;
  localparam int unsigned SumW  = ProdW + 3;

  logic accept;

  // Stage 1: captured operands and twiddle.
  logic  v1_q;
  idx_t  idx1_q;
  coef_t m0e1_q, m0o1_q, m1e1_q, m1o1_q;
  coef_t s0e1_q, s0o1_q, s1e1_q, s1o1_q;
  coef_t ee1_q, eo1_q, g1_q;

  // Stage 2: products.
  logic             v2_q;
  idx_t             idx2_q;
  logic [ProdW-1:0] pee0_q, poo0_q, peo0_q, poe0_q;
  logic [ProdW-1:0] pee1_q, poo1_q, peo1_q, poe1_q;
  coef_t            ee2_q, eo2_q, g2_q;

  // Stage 3: partial sums.
  logic            v3_q;
  idx_t            idx3_q;
  logic [HiW-1:0]  hi3_q;
  logic [EvW-1:0]  ev3_q;
  logic [SumW-1:0] od3_q;
  coef_t           g3_q;

  // Stages 4 and 5: operands waiting for the reduced odd-odd sum.
  idx_t            idx4_q, idx5_q;
  logic [EvW-1:0]  ev4_q, ev5_q;
  logic [SumW-1:0] od4_q, od5_q;
  coef_t           g4_q, g5_q;
  logic            v5;
  coef_t           hi_red;

  // Stage 6: twiddle product.
  logic             v6_q;
  idx_t             idx6_q;
  logic [ProdW-1:0] hg6_q;
  logic [EvW-1:0]   ev6_q;
  logic [SumW-1:0]  od6_q;

  // Stage 7: final sums.
  logic            v7_q;
  idx_t            idx7_q;
  logic [SumW-1:0] ev7_q, od7_q;

  // Stages 8 and 9: index beside the final reduction.
  idx_t  idx8_q, idx9_q;
  logic  od_vld;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v6_q <= v5;
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q <= pair_index_i;
    m0e1_q <= mat0_even_i;
    m0o1_q <= mat0_odd_i;
    m1e1_q <= mat1_even_i;
    m1o1_q <= mat1_odd_i;
    s0e1_q <= sec0_even_i;
    s0o1_q <= sec0_odd_i;
    s1e1_q <= sec1_even_i;
    s1o1_q <= sec1_odd_i;
    ee1_q  <= err_even_i;
    eo1_q  <= err_odd_i;
    g1_q   <= gamma_of(pair_index_i);

    idx2_q <= idx1_q;
    pee0_q <= ProdW'(m0e1_q) * ProdW'(s0e1_q);
    poo0_q <= ProdW'(m0o1_q) * ProdW'(s0o1_q);
    peo0_q <= ProdW'(m0e1_q) * ProdW'(s0o1_q);
    poe0_q <= ProdW'(m0o1_q) * ProdW'(s0e1_q);
    pee1_q <= ProdW'(m1e1_q) * ProdW'(s1e1_q);
    poo1_q <= ProdW'(m1o1_q) * ProdW'(s1o1_q);
    peo1_q <= ProdW'(m1e1_q) * ProdW'(s1o1_q);
    poe1_q <= ProdW'(m1o1_q) * ProdW'(s1e1_q);
    ee2_q  <= ee1_q;
    eo2_q  <= eo1_q;
    g2_q   <= g1_q;

    idx3_q <= idx2_q;
    hi3_q  <= HiW'(poo0_q) + HiW'(poo1_q);
    ev3_q  <= EvW'(pee0_q) + EvW'(pee1_q) + EvW'(ee2_q);
    od3_q  <= SumW'(peo0_q) + SumW'(poe0_q) + SumW'(peo1_q) + SumW'(poe1_q)
              + SumW'(eo2_q);
    g3_q   <= g2_q;

    idx4_q <= idx3_q;
    ev4_q  <= ev3_q;
    od4_q  <= od3_q;
    g4_q   <= g3_q;
    idx5_q <= idx4_q;
    ev5_q  <= ev4_q;
    od5_q  <= od4_q;
    g5_q   <= g4_q;

    idx6_q <= idx5_q;
    hg6_q  <= ProdW'(hi_red) * ProdW'(g5_q);
    ev6_q  <= ev5_q;
    od6_q  <= od5_q;

    idx7_q <= idx6_q;
    ev7_q  <= SumW'(hg6_q) + SumW'(ev6_q);
    od7_q  <= od6_q;

    idx8_q <= idx7_q;
    idx9_q <= idx8_q;
  end

  mbra_modq #(
    .W (HiW)
  ) u_hi_red (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .x_i     (hi3_q),
    .valid_o (v5),
    .r_o     (hi_red)
  );

  mbra_modq #(
    .W (SumW)
  ) u_even_red (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v7_q),
    .x_i     (ev7_q),
    .valid_o (done_o),
    .r_o     (acc_even_o)
  );

  mbra_modq #(
    .W (SumW)
  ) u_odd_red (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v7_q),
    .x_i     (od7_q),
    .valid_o (od_vld),
    .r_o     (acc_odd_o)
  );

  assign out_pair_index_o = idx9_q;

  `MBRA_ASSERT_DELAY(a_lat_fixed, accept, 9, done_o, "Accepted item produced no result.")
  `MBRA_ASSERT_SAME(a_lanes_aligned, 1'b1, done_o == od_vld, "Result halves out of step.")
  `MBRA_ASSERT_SAME(a_result_reduced, done_o, (acc_even_o < Q) && (acc_odd_o < Q),
                    "Result not fully reduced.")
  `MBRA_ASSERT_SAME(a_index_echo, done_o, out_pair_index_o == $past(pair_index_i, 9),
                    "Result carries the wrong pair index.")

endmodule

`default_nettype wire

// File: rtl/mbra_modq.sv
`default_nettype none

module mbra_modq #(
  parameter int unsigned W = 27
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic [W-1:0]         x_i,
  output logic                      valid_o,
  output mbra_pkg::coef_t           r_o
);
  import mbra_pkg::*;

  // Barrett reduction: the quotient estimate is low by at most one.
  localparam int unsigned K  = W + CoefW;
  localparam int unsigned TW = W - CoefW + 1;
  localparam logic [63:0] Mu = (64'd1 << K) / 64'd3329;

  logic [2*W:0]   prod;
  logic           va_q;
  logic [W-1:0]   x_q;
  logic [TW-1:0]  t_q;
  logic [W-1:0]   rem;
  logic [CoefW:0] rem_s;
  coef_t          r_d;
  coef_t          r_q;
  logic           vb_q;

  assign prod = (2*W+1)'(x_i) * (2*W+1)'(Mu[W:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_i;
    t_q <= prod[K +: TW];
  end

  assign rem   = x_q - W'(W'(t_q) * W'(Q));
  assign rem_s = rem[CoefW:0];

  always_comb begin
    if (rem_s >= (CoefW+1)'(Q)) begin
      r_d = coef_t'(rem_s - (CoefW+1)'(Q));
    end else begin
      r_d = rem_s[CoefW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  assign valid_o = vb_q;
  assign r_o     = r_q;

endmodule

`default_nettype wire
